// ----- rtl/skf_pkg.sv -----
// ----------------------------------------------------------------------------
// skf_pkg: shared types and constants of the scalar kalman filter
// register map, reset values and fixed-point widths used by all modules
// ----------------------------------------------------------------------------
package skf_pkg;

	// fixed-point widths
	localparam int unsigned DATA_BITS = 32;               // Q16.16 / Q8.24 words
	localparam int unsigned GAIN_BITS = 25;               // Q0.24 gain, 0..2^24
	localparam int unsigned FRAC_BITS = 24;
	localparam int unsigned PROD_BITS = DATA_BITS + GAIN_BITS;
	localparam int unsigned REM_BITS  = DATA_BITS + 2;    // divider partial remainder
	localparam int unsigned ADDR_BITS = 4;                // four 32-bit registers

	localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(25'h100_0000);

	// register indexes (byte address 4*index)
	localparam logic [1:0] REG_PROCESS_NOISE      = 2'd0;
	localparam logic [1:0] REG_MEASUREMENT_NOISE  = 2'd1;
	localparam logic [1:0] REG_INITIAL_ESTIMATE   = 2'd2;
	localparam logic [1:0] REG_INITIAL_COVARIANCE = 2'd3;

	// register reset values
	localparam logic [DATA_BITS-1:0] RST_PROCESS_NOISE      = 32'd16777;
	localparam logic [DATA_BITS-1:0] RST_MEASUREMENT_NOISE  = 32'd167772;
	localparam logic [DATA_BITS-1:0] RST_INITIAL_ESTIMATE   = 32'd0;
	localparam logic [DATA_BITS-1:0] RST_INITIAL_COVARIANCE = 32'd16777216;

	// configuration seen by the filter core
	typedef struct packed {
		logic [DATA_BITS-1:0] process_noise;
		logic [DATA_BITS-1:0] measurement_noise;
		logic [DATA_BITS-1:0] initial_estimate;
		logic [DATA_BITS-1:0] initial_covariance;
	} cfg_t;

endpackage

// ----- rtl/skf_if.sv -----
// ----------------------------------------------------------------------------
// skf_if: valid/ready channels of the scalar kalman filter
// measurement channel and estimate channel, each with source and sink views
// ----------------------------------------------------------------------------
interface skf_in_if #(
	parameter int unsigned MEAS_BITS = 16
);
	logic                 valid;
	logic                 ready;
	logic [MEAS_BITS-1:0] measurement;
	logic                 restart;

	modport source (output valid, output measurement, output restart, input ready);
	modport sink   (input valid, input measurement, input restart, output ready);
endinterface

interface skf_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] estimate;
	logic [15:0] estimate_integer;

	modport source (output valid, output estimate, output estimate_integer, input ready);
	modport sink   (input valid, input estimate, input estimate_integer, output ready);
endinterface

// ----- rtl/skf_cfg.sv -----
// ----------------------------------------------------------------------------
// skf_cfg: configuration register file
// apb-style write/read port over the four filter registers
// ----------------------------------------------------------------------------
module skf_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [skf_pkg::ADDR_BITS-1:0]   paddr,
	input  logic [skf_pkg::DATA_BITS-1:0]   pwdata,
	output logic [skf_pkg::DATA_BITS-1:0]   prdata,
	output logic                            pready,
	output skf_pkg::cfg_t                   cfg
);

	skf_pkg::cfg_t cfg_q;
	logic [1:0]    reg_idx;
	logic          wr_en;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.process_noise      <= skf_pkg::RST_PROCESS_NOISE;
			cfg_q.measurement_noise  <= skf_pkg::RST_MEASUREMENT_NOISE;
			cfg_q.initial_estimate   <= skf_pkg::RST_INITIAL_ESTIMATE;
			cfg_q.initial_covariance <= skf_pkg::RST_INITIAL_COVARIANCE;
		end else if (wr_en) begin
			unique case (reg_idx)
				skf_pkg::REG_PROCESS_NOISE:      cfg_q.process_noise      <= pwdata;
				skf_pkg::REG_MEASUREMENT_NOISE:  cfg_q.measurement_noise  <= pwdata;
				skf_pkg::REG_INITIAL_ESTIMATE:   cfg_q.initial_estimate   <= pwdata;
				skf_pkg::REG_INITIAL_COVARIANCE: cfg_q.initial_covariance <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			skf_pkg::REG_PROCESS_NOISE:      prdata = cfg_q.process_noise;
			skf_pkg::REG_MEASUREMENT_NOISE:  prdata = cfg_q.measurement_noise;
			skf_pkg::REG_INITIAL_ESTIMATE:   prdata = cfg_q.initial_estimate;
			skf_pkg::REG_INITIAL_COVARIANCE: prdata = cfg_q.initial_covariance;
			default:                         prdata = '0;
		endcase
	end

endmodule

// ----- rtl/skf_core.sv -----
// ----------------------------------------------------------------------------
// skf_core: filter sequencer with shared divide step and shared multiplier
// predict, restoring gain division one bit per cycle, two shared multiplies
// ----------------------------------------------------------------------------
module skf_core #(
	parameter int unsigned MEASUREMENT_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  skf_pkg::cfg_t   cfg,
	skf_in_if.sink          in_ch,
	skf_out_if.source       out_ch
);

	localparam int unsigned DW = skf_pkg::DATA_BITS;
	localparam int unsigned GW = skf_pkg::GAIN_BITS;
	localparam int unsigned FW = skf_pkg::FRAC_BITS;
	localparam int unsigned PW = skf_pkg::PROD_BITS;
	localparam int unsigned RW = skf_pkg::REM_BITS;
	localparam int unsigned ZW = (MEASUREMENT_BITS > 16) ? MEASUREMENT_BITS : 16;
	localparam logic [4:0]  DIV_LAST = 5'(GW - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PRED,
		S_DEN,
		S_DIV,
		S_MUL1,
		S_MUL2,
		S_FIN
	} state_t;

	state_t          state_q;
	logic [DW-1:0]   x_q;        // estimate, Q16.16
	logic [DW-1:0]   p_q;        // covariance, Q8.24
	logic [DW-1:0]   zq_q;       // measurement in Q16.16
	logic [DW-1:0]   pp_q;       // predicted covariance
	logic [DW:0]     den_q;      // pp + R, full width
	logic [RW-1:0]   rem_q;
	logic [GW-1:0]   quo_q;      // gain, Q0.24
	logic [4:0]      cnt_q;
	logic [DW-1:0]   diff_q;
	logic            up_q;
	logic [PW-1:0]   prod_q;
	logic            out_valid_q;
	logic [DW-1:0]   est_q;

	// measurement to Q16.16 with saturation
	logic [ZW-1:0]   z_ext;
	logic            z_over;
	logic [DW-1:0]   zq_w;
	assign z_ext  = ZW'(in_ch.measurement);
	assign z_over = |(z_ext >> 16);
	assign zq_w   = z_over ? '1 : {z_ext[15:0], 16'b0};

	// saturating predict
	logic [DW:0]     pp_sum;
	assign pp_sum = {1'b0, p_q} + {1'b0, cfg.process_noise};

	// shared restoring divide step
	logic [RW-1:0]   den_ext;
	logic            div_bit;
	logic [RW-1:0]   rem_next;
	assign den_ext  = RW'(den_q);
	assign div_bit  = (rem_q >= den_ext) && (den_q != '0);
	assign rem_next = div_bit ? (rem_q - den_ext) : rem_q;

	// shared multiplier
	logic [DW-1:0]   mul_a;
	logic [GW-1:0]   mul_b;
	logic [PW-1:0]   mul_p;
	always_comb begin
		if (state_q == S_MUL1) begin
			mul_a = diff_q;
			mul_b = quo_q;
		end else begin
			mul_a = pp_q;
			mul_b = skf_pkg::GAIN_ONE - quo_q;
		end
	end
	assign mul_p = PW'(mul_a) * PW'(mul_b);

	logic [DW-1:0]   prod_hi;
	assign prod_hi = prod_q[FW +: DW];

	assign in_ch.ready             = (state_q == S_IDLE);
	assign out_ch.valid            = out_valid_q;
	assign out_ch.estimate         = est_q;
	assign out_ch.estimate_integer = est_q[DW-1:16];

	// sequencer, filter state and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			x_q         <= skf_pkg::RST_INITIAL_ESTIMATE;
			p_q         <= skf_pkg::RST_INITIAL_COVARIANCE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			// a taken word frees the output unless a new one is loaded now
			if (out_valid_q && out_ch.ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						zq_q <= zq_w;
						if (in_ch.restart) begin
							x_q <= cfg.initial_estimate;
							p_q <= cfg.initial_covariance;
						end
						state_q <= S_PRED;
					end
				end
				S_PRED: begin
					pp_q <= pp_sum[DW] ? '1 : pp_sum[DW-1:0];
					if (zq_q >= x_q) begin
						diff_q <= zq_q - x_q;
						up_q   <= 1'b1;
					end else begin
						diff_q <= x_q - zq_q;
						up_q   <= 1'b0;
					end
					state_q <= S_DEN;
				end
				S_DEN: begin
					den_q   <= {1'b0, pp_q} + {1'b0, cfg.measurement_noise};
					rem_q   <= RW'(pp_q);
					quo_q   <= '0;
					cnt_q   <= DIV_LAST;
					state_q <= S_DIV;
				end
				S_DIV: begin
					quo_q <= {quo_q[GW-2:0], div_bit};
					rem_q <= {rem_next[RW-2:0], 1'b0};
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: begin
					prod_q  <= mul_p;
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					x_q     <= up_q ? (x_q + prod_hi) : (x_q - prod_hi);
					prod_q  <= mul_p;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || out_ch.ready) begin
						p_q         <= prod_hi;
						est_q       <= x_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/scalar_kalman_filter_top.sv -----
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top: one-dimensional kalman filter for heading samples
// an accepted measurement runs predict, denominator, the 25-step gain division,
// two multiplies, then waits for a free output to load the estimate word;
// the input is not ready while a measurement is in work
// reset: async, active low; registers and filter state take their reset values
// ----------------------------------------------------------------------------
module scalar_kalman_filter_top #(
	parameter int unsigned MEASUREMENT_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [skf_pkg::ADDR_BITS-1:0]   paddr,
	input  logic [skf_pkg::DATA_BITS-1:0]   pwdata,
	output logic [skf_pkg::DATA_BITS-1:0]   prdata,
	output logic                            pready,
	skf_in_if.sink                          in_ch,
	skf_out_if.source                       out_ch
);

	skf_pkg::cfg_t cfg;

	// configuration registers
	skf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// filter core
	skf_core #(
		.MEASUREMENT_BITS (MEASUREMENT_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule
